// ===== hdl/deq_pkg.sv =====
// ============================================================================
// Deadline expiry queue package
// Shared constants, payload types, codes and helpers for the deadline queue.
// ============================================================================
package deq_pkg;

  // Storage geometry.
  localparam int DEPTH     = 32;
  localparam int TIME_BITS = 32;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (CNT_W > 6) ? CNT_W : 6;
  localparam int TEXT_W    = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int ENTRY_W   = 16 + TIME_BITS;

  // Register reset value and the hard cap on one take.
  localparam logic [5:0] CAP_RESET  = 6'd32;
  localparam logic [5:0] TAKE_LIMIT = 6'd32;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_TAKE   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_INVALID   = 3'd1,
    STS_DUPLICATE = 3'd2,
    STS_CAPACITY  = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_DN_RD,
    S_DN_WR,
    S_TAKE_RD,
    S_TAKE_CHK,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_id;
    logic [31:0] deadline;
    logic [31:0] now;
    logic [5:0]  max_take;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        item_valid;
    logic [15:0] expired_id;
    logic        last;
    logic        head_expired;
    logic [5:0]  entry_count;
  } out_item_t;

  // One stored queue entry.
  typedef struct packed {
    logic [15:0] id;
    time_t       dl;
  } entry_t;

  // Result of the shared entry comparator.
  typedef struct packed {
    logic id_eq;
    logic time_le;
  } cmp_res_t;

  // Keep the low TIME_BITS bits of a 32-bit tick value.
  function automatic time_t to_time(input logic [31:0] x);
    logic [TEXT_W-1:0] w;
    w = TEXT_W'(x);
    return w[TIME_BITS-1:0];
  endfunction

endpackage

// ===== hdl/deq_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/deq_cmp.sv =====
// ============================================================================
// Deadline queue entry comparator
// Shared unit that checks one stored entry against the id and time keys.
// ============================================================================
module deq_cmp (
  input  deq_pkg::entry_t   entry,
  input  logic [15:0]       key_id,
  input  deq_pkg::time_t    key_time,
  output deq_pkg::cmp_res_t res
);

  // Id match and "deadline not after key time" are the only tests needed.
  always_comb begin
    res.id_eq   = (entry.id == key_id);
    res.time_le = (entry.dl <= key_time);
  end

endmodule

// ===== hdl/deadline_expiry_queue_top.sv =====
// Operation: a query reads the head and returns its result; insert and erase
//   scan the stored entries, then shift entries to open or close a slot.
// Take: each removed id shifts the remaining entries down and returns one result.
// Throughput: one transaction at a time; the single RAM port pair and the
//   shared comparator set the pace. in_ready is high only while idle.
// Reset: synchronous, active low; count clears to 0 and capacity_limit to 32.
// ============================================================================
// Deadline expiry queue
// Sorted deadline queue with keyed erase, held in a RAM and walked by a
// small sequencer around one shared entry comparator.
// ============================================================================
module deadline_expiry_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data
);

  localparam int CNT_W = deq_pkg::CNT_W;
  localparam int AW    = deq_pkg::AW;
  localparam int CMP_W = deq_pkg::CMP_W;

  deq_pkg::state_t  state_r, state_nxt;
  deq_pkg::op_t     op_r, op_nxt;
  deq_pkg::status_t status_r, status_nxt;
  logic [15:0]      id_r, id_nxt;
  deq_pkg::time_t   dl_r, dl_nxt;
  deq_pkg::time_t   now_r, now_nxt;
  logic [5:0]       limit_r, limit_nxt;
  logic [5:0]       taken_r, taken_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [5:0]       cap_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] ins_pos_r, ins_pos_nxt;
  logic             found_r, found_nxt;
  logic             ins_found_r, ins_found_nxt;
  logic             item_r, item_nxt;
  logic [15:0]      tid_r, tid_nxt;
  logic             more_r, more_nxt;
  deq_pkg::out_item_t out_r, out_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [AW-1:0]            ram_raddr;
  logic [deq_pkg::ENTRY_W-1:0] ram_wdata;
  logic [deq_pkg::ENTRY_W-1:0] ram_rdata;

  deq_pkg::entry_t   rd_entry;
  deq_pkg::entry_t   new_entry;
  deq_pkg::time_t    key_time;
  deq_pkg::cmp_res_t cmp;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic [CMP_W-1:0] count_ext;
  logic             queue_full;
  logic             hexp;

  assign rd_entry  = deq_pkg::entry_t'(ram_rdata);
  assign new_entry = '{id: id_r, dl: dl_r};
  assign idx_inc   = idx_r + CNT_W'(1);
  assign idx_dec   = idx_r - CNT_W'(1);
  assign count_ext = CMP_W'(count_r);
  assign queue_full = (count_ext >= CMP_W'(cap_r)) || (count_r >= CNT_W'(deq_pkg::DEPTH));
  assign hexp      = (count_r != '0) && cmp.time_le;

  // Entry storage.
  deq_ram #(
    .WIDTH (deq_pkg::ENTRY_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The scan orders by the insert deadline; everything else tests against now.
  assign key_time = (state_r == deq_pkg::S_SCAN_CHK) ? dl_r : now_r;

  deq_cmp u_cmp (
    .entry    (rd_entry),
    .key_id   (id_r),
    .key_time (key_time),
    .res      (cmp)
  );

  // Handshake outputs.
  assign in_ready  = (state_r == deq_pkg::S_IDLE);
  assign out_valid = (state_r == deq_pkg::S_OUT);
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= deq_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    status_r    <= status_nxt;
    id_r        <= id_nxt;
    dl_r        <= dl_nxt;
    now_r       <= now_nxt;
    limit_r     <= limit_nxt;
    taken_r     <= taken_nxt;
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    ins_pos_r   <= ins_pos_nxt;
    found_r     <= found_nxt;
    ins_found_r <= ins_found_nxt;
    item_r      <= item_nxt;
    tid_r       <= tid_nxt;
    more_r      <= more_nxt;
    out_r       <= out_nxt;
  end

  // Sequencer: next state, RAM control and result assembly.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    status_nxt    = status_r;
    id_nxt        = id_r;
    dl_nxt        = dl_r;
    now_nxt       = now_r;
    limit_nxt     = limit_r;
    taken_nxt     = taken_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    ins_pos_nxt   = ins_pos_r;
    found_nxt     = found_r;
    ins_found_nxt = ins_found_r;
    item_nxt      = item_r;
    tid_nxt       = tid_r;
    more_nxt      = more_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;

    case (state_r)
      deq_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt        = deq_pkg::op_t'(in_data.opcode);
          id_nxt        = in_data.request_id;
          dl_nxt        = deq_pkg::to_time(in_data.deadline);
          now_nxt       = deq_pkg::to_time(in_data.now);
          limit_nxt     = (in_data.max_take > deq_pkg::TAKE_LIMIT) ?
                          deq_pkg::TAKE_LIMIT : in_data.max_take;
          taken_nxt     = '0;
          idx_nxt       = '0;
          found_nxt     = 1'b0;
          ins_found_nxt = 1'b0;
          item_nxt      = 1'b0;
          tid_nxt       = '0;
          status_nxt    = deq_pkg::STS_OK;
          case (deq_pkg::op_t'(in_data.opcode))
            deq_pkg::OP_INSERT, deq_pkg::OP_ERASE: begin
              if (in_data.request_id == '0) begin
                status_nxt = (deq_pkg::op_t'(in_data.opcode) == deq_pkg::OP_INSERT) ?
                             deq_pkg::STS_INVALID : deq_pkg::STS_NOT_FOUND;
                state_nxt  = deq_pkg::S_HEAD_RD;
              end else if (count_r == '0) begin
                state_nxt = deq_pkg::S_DECIDE;
              end else begin
                state_nxt = deq_pkg::S_SCAN_RD;
              end
            end
            deq_pkg::OP_TAKE: begin
              state_nxt = deq_pkg::S_TAKE_RD;
            end
            default: begin
              state_nxt = deq_pkg::S_HEAD_RD;
            end
          endcase
        end
      end

      // Walk the entries for an id match and the insert position.
      deq_pkg::S_SCAN_RD: begin
        ram_raddr = idx_r[AW-1:0];
        state_nxt = deq_pkg::S_SCAN_CHK;
      end

      deq_pkg::S_SCAN_CHK: begin
        if (cmp.id_eq) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        if ((op_r == deq_pkg::OP_INSERT) && !ins_found_r && !cmp.time_le) begin
          ins_found_nxt = 1'b1;
          ins_pos_nxt   = idx_r;
        end
        idx_nxt = idx_inc;
        if ((idx_inc == count_r) || ((op_r == deq_pkg::OP_ERASE) && cmp.id_eq)) begin
          state_nxt = deq_pkg::S_DECIDE;
        end else begin
          state_nxt = deq_pkg::S_SCAN_RD;
        end
      end

      // Settle the outcome of an insert or erase after the scan.
      deq_pkg::S_DECIDE: begin
        if (op_r == deq_pkg::OP_INSERT) begin
          if (found_r) begin
            status_nxt = deq_pkg::STS_DUPLICATE;
            state_nxt  = deq_pkg::S_HEAD_RD;
          end else if (queue_full) begin
            status_nxt = deq_pkg::STS_CAPACITY;
            state_nxt  = deq_pkg::S_HEAD_RD;
          end else begin
            pos_nxt = ins_found_r ? ins_pos_r : count_r;
            idx_nxt = count_r;
            if (count_r > pos_nxt) begin
              state_nxt = deq_pkg::S_UP_RD;
            end else begin
              state_nxt = deq_pkg::S_INS_WR;
            end
          end
        end else begin
          if (found_r) begin
            idx_nxt   = pos_r;
            state_nxt = deq_pkg::S_DN_RD;
          end else begin
            status_nxt = deq_pkg::STS_NOT_FOUND;
            state_nxt  = deq_pkg::S_HEAD_RD;
          end
        end
      end

      // Open a hole at the insert position, moving entries up by one.
      deq_pkg::S_UP_RD: begin
        ram_raddr = idx_dec[AW-1:0];
        state_nxt = deq_pkg::S_UP_WR;
      end

      deq_pkg::S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_dec;
        if (idx_dec > pos_r) begin
          state_nxt = deq_pkg::S_UP_RD;
        end else begin
          state_nxt = deq_pkg::S_INS_WR;
        end
      end

      deq_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = new_entry;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = deq_pkg::S_HEAD_RD;
      end

      // Close the gap at idx, moving later entries down by one.
      deq_pkg::S_DN_RD: begin
        if (idx_inc < count_r) begin
          ram_raddr = idx_inc[AW-1:0];
          state_nxt = deq_pkg::S_DN_WR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = deq_pkg::S_HEAD_RD;
        end
      end

      deq_pkg::S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        state_nxt = deq_pkg::S_DN_RD;
      end

      // Take: remove the head if it has expired and the limit allows.
      deq_pkg::S_TAKE_RD: begin
        ram_raddr = '0;
        state_nxt = deq_pkg::S_TAKE_CHK;
      end

      deq_pkg::S_TAKE_CHK: begin
        if ((taken_r < limit_r) && hexp) begin
          item_nxt  = 1'b1;
          tid_nxt   = rd_entry.id;
          taken_nxt = taken_r + 6'd1;
          idx_nxt   = '0;
          state_nxt = deq_pkg::S_DN_RD;
        end else begin
          item_nxt  = 1'b0;
          tid_nxt   = '0;
          state_nxt = deq_pkg::S_HEAD_RD;
        end
      end

      // Look at the head after the change and build the result.
      deq_pkg::S_HEAD_RD: begin
        ram_raddr = '0;
        state_nxt = deq_pkg::S_HEAD_CHK;
      end

      deq_pkg::S_HEAD_CHK: begin
        more_nxt = (op_r == deq_pkg::OP_TAKE) && item_r && (taken_r < limit_r) && hexp;
        out_nxt.status       = status_r;
        out_nxt.item_valid   = item_r;
        out_nxt.expired_id   = item_r ? tid_r : 16'd0;
        out_nxt.last         = !more_nxt;
        out_nxt.head_expired = hexp;
        out_nxt.entry_count  = count_ext[5:0];
        state_nxt            = deq_pkg::S_OUT;
      end

      deq_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = more_r ? deq_pkg::S_TAKE_RD : deq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

  // The count never passes the storage depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(deq_pkg::DEPTH))
    else $error("entry count exceeds depth");

  // A new item is never taken while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // RAM writes happen only in the shift and insert steps.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == deq_pkg::S_UP_WR || state_r == deq_pkg::S_DN_WR ||
                state_r == deq_pkg::S_INS_WR))
    else $error("RAM write outside a write step");

  // The insert write step grows the queue by exactly one entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == deq_pkg::S_INS_WR) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count by one");

  // A result only leaves after the head check step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == deq_pkg::S_HEAD_CHK))
    else $error("result raised without a head check");

endmodule

// ===== tb/tb_deadline_expiry_queue_top.sv =====
// ============================================================================
// Deadline expiry queue testbench
// Drives insert, erase, take and query transactions into the queue under
// changing capacity settings and random idling on both channels, predicts
// every result from a private copy of the sorted queue and compares each
// returned result field by field in order.
// ============================================================================
module tb_deadline_expiry_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int PRINT_LIMIT = 40;

  // Scoreboard: sorted copy of the queue and the results it must produce.
  class deq_scoreboard;
    bit [15:0]          ids[deq_pkg::DEPTH];
    deq_pkg::time_t     dls[deq_pkg::DEPTH];
    int                 count;
    bit [5:0]           cap;
    deq_pkg::out_item_t pending[$];
    int                 mismatches;
    int                 n_requests;
    int                 n_results;
    int                 n_taken;
    int                 n_full;

    function new();
      count = 0;
      cap = deq_pkg::CAP_RESET;
      mismatches = 0;
      n_requests = 0;
      n_results = 0;
      n_taken = 0;
      n_full = 0;
    endfunction

    function void set_capacity(bit [5:0] v);
      cap = v;
    endfunction

    function int find_slot(bit [15:0] id);
      for (int i = 0; i < count; i++) begin
        if (ids[i] == id) return i;
      end
      return -1;
    endfunction

    function void drop_slot(int pos);
      for (int i = pos; i + 1 < count; i++) begin
        ids[i] = ids[i + 1];
        dls[i] = dls[i + 1];
      end
      if (count > 0) count--;
    endfunction

    // Builds one expected result from the state after its change.
    function void push_result(deq_pkg::status_t st, bit vld, bit [15:0] id, bit lst,
                              deq_pkg::time_t now);
      deq_pkg::out_item_t r;
      r.status       = st;
      r.item_valid   = vld;
      r.expired_id   = id;
      r.last         = lst;
      r.head_expired = (count > 0) && (dls[0] <= now);
      r.entry_count  = count[5:0];
      pending.push_back(r);
    endfunction

    // Applies one accepted transaction and queues the results it causes.
    function void note_request(deq_pkg::in_item_t it);
      bit [15:0]        id;
      deq_pkg::time_t   dl;
      deq_pkg::time_t   now;
      deq_pkg::status_t st;
      int               pos;
      int               limit;
      int               taken;
      bit [15:0]        tid;
      bit               more;
      id  = it.request_id;
      dl  = deq_pkg::to_time(it.deadline);
      now = deq_pkg::to_time(it.now);
      n_requests++;
      case (deq_pkg::op_t'(it.opcode))
        deq_pkg::OP_INSERT: begin
          st = deq_pkg::STS_OK;
          if (id == 16'd0) begin
            st = deq_pkg::STS_INVALID;
          end else if (find_slot(id) >= 0) begin
            st = deq_pkg::STS_DUPLICATE;
          end else if (count >= int'(cap) || count >= deq_pkg::DEPTH) begin
            st = deq_pkg::STS_CAPACITY;
            n_full++;
          end else begin
            // New entry goes after every entry that is not later.
            pos = 0;
            while (pos < count && dls[pos] <= dl) pos++;
            for (int i = count; i > pos; i--) begin
              ids[i] = ids[i - 1];
              dls[i] = dls[i - 1];
            end
            ids[pos] = id;
            dls[pos] = dl;
            count++;
          end
          push_result(st, 1'b0, 16'd0, 1'b1, now);
        end
        deq_pkg::OP_ERASE: begin
          pos = find_slot(id);
          st = deq_pkg::STS_NOT_FOUND;
          if (id != 16'd0 && pos >= 0) begin
            drop_slot(pos);
            st = deq_pkg::STS_OK;
          end
          push_result(st, 1'b0, 16'd0, 1'b1, now);
        end
        deq_pkg::OP_TAKE: begin
          limit = (it.max_take < deq_pkg::TAKE_LIMIT) ? int'(it.max_take)
                                                      : int'(deq_pkg::TAKE_LIMIT);
          taken = 0;
          while (taken < limit && count > 0 && dls[0] <= now) begin
            tid = ids[0];
            drop_slot(0);
            more = (taken + 1 < limit) && (count > 0) && (dls[0] <= now);
            push_result(deq_pkg::STS_OK, 1'b1, tid, !more, now);
            taken++;
          end
          n_taken += taken;
          if (taken == 0) push_result(deq_pkg::STS_OK, 1'b0, 16'd0, 1'b1, now);
        end
        default: begin
          push_result(deq_pkg::STS_OK, 1'b0, 16'd0, 1'b1, now);
        end
      endcase
    endfunction

    task report_mismatch(string what, longint got_v, longint exp_v);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 n_results, what, got_v, exp_v);
      end
    endtask

    // Compares one returned result with the oldest expectation.
    task check_result(deq_pkg::out_item_t got);
      deq_pkg::out_item_t want;
      n_results++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, -1);
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status)
        report_mismatch("status", got.status, want.status);
      if (got.item_valid != want.item_valid)
        report_mismatch("item_valid", got.item_valid, want.item_valid);
      if (got.expired_id != want.expired_id)
        report_mismatch("expired_id", got.expired_id, want.expired_id);
      if (got.last != want.last)
        report_mismatch("last", got.last, want.last);
      if (got.head_expired != want.head_expired)
        report_mismatch("head_expired", got.head_expired, want.head_expired);
      if (got.entry_count != want.entry_count)
        report_mismatch("entry_count", got.entry_count, want.entry_count);
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  deq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  deq_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [5:0]         cfg_data;

  deq_scoreboard sb;
  int            send_idle;
  int            recv_idle;
  logic [31:0]   now_tick;
  int            cycles;

  deadline_expiry_queue_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cycle counter that ends a hung run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[deadline_expiry_queue_top] ERROR");
    $finish;
  end

  // Result side: check every accepted result and stall at random.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Presents one transaction, optionally after a short gap, and waits for it.
  task automatic send_item(input deq_pkg::in_item_t it);
    int gap;
    if ($urandom_range(0, 99) < send_idle) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic send_op(input deq_pkg::op_t op, input logic [15:0] id,
                         input logic [31:0] dl, input logic [31:0] now,
                         input logic [5:0] mt);
    deq_pkg::in_item_t it;
    it.opcode     = op;
    it.request_id = id;
    it.deadline   = dl;
    it.now        = now;
    it.max_take   = mt;
    send_item(it);
  endtask

  // Waits until every expected result is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the capacity register; the block must be idle.
  task automatic write_capacity(input logic [5:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_capacity(v);
    cfg_valid <= 1'b0;
  endtask

  // Random transaction around a slowly advancing clock of ticks.
  function automatic deq_pkg::in_item_t random_request(input int insert_pct);
    deq_pkg::in_item_t it;
    int                r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      it.opcode = deq_pkg::OP_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) it.opcode = deq_pkg::OP_ERASE;
      else if (r < 75) it.opcode = deq_pkg::OP_TAKE;
      else it.opcode = deq_pkg::OP_QUERY;
    end
    r = $urandom_range(0, 99);
    if (r < 5) it.request_id = 16'd0;
    else if (r < 15) it.request_id = 16'($urandom());
    else it.request_id = 16'($urandom_range(1, 64));
    // Erases mostly name an entry that is really held.
    if (it.opcode == deq_pkg::OP_ERASE && sb.count > 0 && $urandom_range(0, 99) < 70)
      it.request_id = sb.ids[$urandom_range(0, sb.count - 1)];
    now_tick = now_tick + $urandom_range(0, 12);
    it.now = ($urandom_range(0, 99) < 5) ? 32'($urandom()) : now_tick;
    it.deadline = ($urandom_range(0, 99) < 8) ? 32'($urandom())
                                               : now_tick + $urandom_range(0, 80);
    r = $urandom_range(0, 99);
    if (r < 80) it.max_take = 6'($urandom_range(1, 6));
    else if (r < 95) it.max_take = 6'($urandom_range(0, 32));
    else it.max_take = 6'($urandom_range(33, 63));
    return it;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(random_request((i < 45) ? 85 : 35));
    end
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    logic [5:0] mid_cap;
    sb = new();
    send_idle = 20;
    recv_idle = 68;
    now_tick  = 32'd1000;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue, invalid id, tie order on equal deadlines, extremes.
    send_op(deq_pkg::OP_QUERY,  16'd0,    32'd0,         32'd0,         6'd0);
    send_op(deq_pkg::OP_TAKE,   16'd0,    32'd0,         32'd0,         6'd5);
    send_op(deq_pkg::OP_INSERT, 16'd0,    32'd50,        32'd0,         6'd0);
    send_op(deq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,         6'd0);
    send_op(deq_pkg::OP_INSERT, 16'd1,    32'd100,       32'd0,         6'd0);
    send_op(deq_pkg::OP_INSERT, 16'd2,    32'd100,       32'd0,         6'd0);
    send_op(deq_pkg::OP_INSERT, 16'd3,    32'd0,         32'd0,         6'd0);
    send_op(deq_pkg::OP_INSERT, 16'd1,    32'd7,         32'd0,         6'd0);
    send_op(deq_pkg::OP_QUERY,  16'd0,    32'd0,         32'd0,         6'd0);
    send_op(deq_pkg::OP_ERASE,  16'd0,    32'd0,         32'd0,         6'd0);
    send_op(deq_pkg::OP_ERASE,  16'h1234, 32'd0,         32'd0,         6'd0);
    send_op(deq_pkg::OP_ERASE,  16'd2,    32'd0,         32'd0,         6'd0);
    send_op(deq_pkg::OP_TAKE,   16'd0,    32'd0,         32'd100,       6'd0);
    send_op(deq_pkg::OP_TAKE,   16'd0,    32'd0,         32'd100,       6'd1);
    send_op(deq_pkg::OP_INSERT, 16'd2,    32'd100,       32'd100,       6'd0);
    send_op(deq_pkg::OP_TAKE,   16'd0,    32'd0,         32'hFFFF_FFFF, 6'd63);
    send_op(deq_pkg::OP_QUERY,  16'd0,    32'd0,         32'hFFFF_FFFF, 6'd0);

    // Small capacity, then none at all; duplicate wins over capacity.
    write_capacity(6'd2);
    send_op(deq_pkg::OP_INSERT, 16'd10,   32'd5,         32'd0,         6'd0);
    send_op(deq_pkg::OP_INSERT, 16'd11,   32'd5,         32'd0,         6'd0);
    send_op(deq_pkg::OP_INSERT, 16'd12,   32'd1,         32'd0,         6'd0);
    send_op(deq_pkg::OP_ERASE,  16'd10,   32'd0,         32'd0,         6'd0);
    send_op(deq_pkg::OP_TAKE,   16'd0,    32'd0,         32'd4,         6'd32);
    write_capacity(6'd0);
    send_op(deq_pkg::OP_INSERT, 16'd20,   32'd5,         32'd0,         6'd0);
    send_op(deq_pkg::OP_INSERT, 16'd11,   32'd5,         32'd0,         6'd0);
    send_op(deq_pkg::OP_TAKE,   16'd0,    32'd0,         32'd5,         6'd32);

    // Random part under three idle mixes and several capacities.
    write_capacity(6'd32);
    random_phase(85);
    mid_cap = 6'($urandom_range(1, 31));
    write_capacity(mid_cap);
    send_idle = 68;
    recv_idle = 20;
    random_phase(85);
    write_capacity(6'd32);
    send_idle = 0;
    recv_idle = 0;
    random_phase(85);

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d transactions and checked %0d results, %0d of them expired entries.",
             sb.n_requests, sb.n_results, sb.n_taken);
    $display("Capacities 32, 2, 0, %0d and 32 were used; %0d inserts hit the limit.",
             mid_cap, sb.n_full);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[deadline_expiry_queue_top] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               sb.mismatches, sb.pending.size());
      $display("[deadline_expiry_queue_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_cmp.sv
hdl/deadline_expiry_queue_top.sv
tb/tb_deadline_expiry_queue_top.sv
